FILE: hw/rtl/egs_pkg.sv
package egs_pkg;

   localparam logic [31:0] PRIME_RESET = 32'd3119;
   localparam logic [31:0] GEN_RESET   = 32'd2;
   localparam logic [31:0] KEY_RESET   = 32'd127;

   // configuration register indexes
   localparam logic [1:0] CSR_PRIME = 2'd0;
   localparam logic [1:0] CSR_GEN   = 2'd1;
   localparam logic [1:0] CSR_KEY   = 2'd2;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_TAKE,   // latch request fields
      CMD_LOAD,   // dst <= a
      CMD_MUL,    // dst <= a*b mod n, b < n, serial
      CMD_DIV,    // q <= a/b, dst <= a%b, serial
      CMD_SUBM,   // dst <= (a-b) mod n, a,b < n
      CMD_SHL,    // exponent shift
      CMD_OUT     // load result register
   } cmd_kind_type;

   typedef enum logic [4:0] {
      OPD_ZERO, OPD_ONE, OPD_P, OPD_PM1, OPD_G, OPD_D,
      OPD_MSG, OPD_NONCE, OPD_SIN1, OPD_SIN2,
      OPD_PUB, OPD_S1, OPD_S2, OPD_ACC, OPD_BASE, OPD_EX,
      OPD_R0, OPD_R1, OPD_T0, OPD_T1, OPD_Q, OPD_TMP, OPD_V1, OPD_V2
   } opd_type;

   typedef enum logic [1:0] {
      OUT_BAD,     // modulus below three
      OUT_NOINV,   // nonce not invertible
      OUT_SIGN,
      OUT_VERIFY
   } out_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      opd_type      a;
      opd_type      b;
      opd_type      dst;
      logic         mod_pm1;   // reduce modulo p-1 instead of p
      out_kind_type outk;
   } cmd_type;

   typedef struct packed {
      logic done;       // serial unit finished, result written
      logic ex_msb;
      logic r1_zero;
      logic r0_one;
      logic p_small;
      logic op_verify;
      logic rsp_free;
   } sts_type;

endpackage

FILE: hw/rtl/egs_datapath.sv
module egs_datapath #(
   parameter int WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  egs_pkg::cmd_type      cmd,
   output egs_pkg::sts_type      sts,
   input  logic                  req_op,
   input  logic [WORD_BITS-1:0]  req_message,
   input  logic [WORD_BITS-1:0]  req_nonce,
   input  logic [WORD_BITS-1:0]  req_sig_first,
   input  logic [WORD_BITS-1:0]  req_sig_second,
   input  logic [WORD_BITS-1:0]  cfg_prime,
   input  logic [WORD_BITS-1:0]  cfg_gen,
   input  logic [WORD_BITS-1:0]  cfg_key,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [WORD_BITS-1:0]  rsp_public_key,
   output logic [WORD_BITS-1:0]  rsp_sig_first,
   output logic [WORD_BITS-1:0]  rsp_sig_second,
   output logic                  rsp_sig_ok,
   output logic                  rsp_status
);

   localparam int W     = WORD_BITS;
   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0] pm1;
   logic         op_ff;
   logic [W-1:0] msg_ff, nonce_ff, sin1_ff, sin2_ff;
   logic [W-1:0] pub_ff, s1_ff, s2_ff, acc_ff, base_ff, ex_ff;
   logic [W-1:0] r0_ff, r1_ff, t0_ff, t1_ff, q_ff, tmp_ff, v1_ff, v2_ff;

   // serial multiply / divide unit
   logic             busy_ff, done_ff, div_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [W-1:0]     sa_ff, sb_ff, sn_ff, sacc_ff;
   egs_pkg::opd_type sdst_ff;
   logic [W:0]       dbl, dbl_red, add, add_red, rem_sh, rem_sub;
   logic [W-1:0]     step_acc, step_sa;

   logic [W-1:0] opa, opb, modn;
   logic [W:0]   subm_val;
   logic         wr_en;
   egs_pkg::opd_type wr_dst;
   logic [W-1:0] wr_val;

   logic         rsp_valid_ff;
   logic [W-1:0] out_pub_ff, out_s1_ff, out_s2_ff;
   logic         out_ok_ff, out_status_ff;

   function automatic logic [W-1:0] pick(input egs_pkg::opd_type sel,
         input logic [W-1:0] p, input logic [W-1:0] n1);
      case (sel)
         egs_pkg::OPD_ZERO:  pick = '0;
         egs_pkg::OPD_ONE:   pick = W'(1);
         egs_pkg::OPD_P:     pick = p;
         egs_pkg::OPD_PM1:   pick = n1;
         egs_pkg::OPD_G:     pick = cfg_gen;
         egs_pkg::OPD_D:     pick = cfg_key;
         egs_pkg::OPD_MSG:   pick = msg_ff;
         egs_pkg::OPD_NONCE: pick = nonce_ff;
         egs_pkg::OPD_SIN1:  pick = sin1_ff;
         egs_pkg::OPD_SIN2:  pick = sin2_ff;
         egs_pkg::OPD_PUB:   pick = pub_ff;
         egs_pkg::OPD_S1:    pick = s1_ff;
         egs_pkg::OPD_S2:    pick = s2_ff;
         egs_pkg::OPD_ACC:   pick = acc_ff;
         egs_pkg::OPD_BASE:  pick = base_ff;
         egs_pkg::OPD_EX:    pick = ex_ff;
         egs_pkg::OPD_R0:    pick = r0_ff;
         egs_pkg::OPD_R1:    pick = r1_ff;
         egs_pkg::OPD_T0:    pick = t0_ff;
         egs_pkg::OPD_T1:    pick = t1_ff;
         egs_pkg::OPD_Q:     pick = q_ff;
         egs_pkg::OPD_TMP:   pick = tmp_ff;
         egs_pkg::OPD_V1:    pick = v1_ff;
         egs_pkg::OPD_V2:    pick = v2_ff;
         default:            pick = '0;
      endcase
   endfunction

   assign pm1  = cfg_prime - W'(1);
   assign opa  = pick(cmd.a, cfg_prime, pm1);
   assign opb  = pick(cmd.b, cfg_prime, pm1);
   assign modn = cmd.mod_pm1 ? pm1 : cfg_prime;

   assign subm_val = (opa >= opb) ? ({1'b0, opa} - {1'b0, opb})
                                  : ({1'b0, opa} + {1'b0, modn} - {1'b0, opb});

   // one step: MSB-first shift-add modular product, or restoring division
   always_comb begin
      dbl     = {sacc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, sn_ff}) ? dbl - {1'b0, sn_ff} : dbl;
      add     = dbl_red + (sa_ff[W-1] ? {1'b0, sb_ff} : '0);
      add_red = (add >= {1'b0, sn_ff}) ? add - {1'b0, sn_ff} : add;
      rem_sh  = {sacc_ff, sa_ff[W-1]};
      rem_sub = rem_sh - {1'b0, sb_ff};
      if (div_ff) begin
         if (rem_sh >= {1'b0, sb_ff}) begin
            step_acc = rem_sub[W-1:0];
            step_sa  = {sa_ff[W-2:0], 1'b1};
         end else begin
            step_acc = rem_sh[W-1:0];
            step_sa  = {sa_ff[W-2:0], 1'b0};
         end
      end else begin
         step_acc = add_red[W-1:0];
         step_sa  = {sa_ff[W-2:0], 1'b0};
      end
   end

   always_comb begin
      wr_en  = 1'b0;
      wr_dst = cmd.dst;
      wr_val = opa;
      if (busy_ff && cnt_ff == CNT_W'(1)) begin
         wr_en  = 1'b1;
         wr_dst = sdst_ff;
         wr_val = step_acc;
      end else begin
         case (cmd.kind)
            egs_pkg::CMD_LOAD: wr_en = 1'b1;
            egs_pkg::CMD_SUBM: begin
               wr_en  = 1'b1;
               wr_val = subm_val[W-1:0];
            end
            default: wr_en = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(1));
         if (busy_ff) begin
            cnt_ff  <= cnt_ff - CNT_W'(1);
            sacc_ff <= step_acc;
            sa_ff   <= step_sa;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               if (div_ff) q_ff <= step_sa;
            end
         end else if (cmd.kind == egs_pkg::CMD_MUL || cmd.kind == egs_pkg::CMD_DIV) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(W);
            div_ff  <= (cmd.kind == egs_pkg::CMD_DIV);
            sa_ff   <= opa;
            sb_ff   <= opb;
            sn_ff   <= modn;
            sacc_ff <= '0;
            sdst_ff <= cmd.dst;
         end

         if (cmd.kind == egs_pkg::CMD_TAKE) begin
            op_ff    <= req_op;
            msg_ff   <= req_message;
            nonce_ff <= req_nonce;
            sin1_ff  <= req_sig_first;
            sin2_ff  <= req_sig_second;
         end
         if (cmd.kind == egs_pkg::CMD_SHL) ex_ff <= {ex_ff[W-2:0], 1'b0};

         if (wr_en) begin
            case (wr_dst)
               egs_pkg::OPD_PUB:  pub_ff  <= wr_val;
               egs_pkg::OPD_S1:   s1_ff   <= wr_val;
               egs_pkg::OPD_S2:   s2_ff   <= wr_val;
               egs_pkg::OPD_ACC:  acc_ff  <= wr_val;
               egs_pkg::OPD_BASE: base_ff <= wr_val;
               egs_pkg::OPD_EX:   ex_ff   <= wr_val;
               egs_pkg::OPD_R0:   r0_ff   <= wr_val;
               egs_pkg::OPD_R1:   r1_ff   <= wr_val;
               egs_pkg::OPD_T0:   t0_ff   <= wr_val;
               egs_pkg::OPD_T1:   t1_ff   <= wr_val;
               egs_pkg::OPD_TMP:  tmp_ff  <= wr_val;
               egs_pkg::OPD_V1:   v1_ff   <= wr_val;
               egs_pkg::OPD_V2:   v2_ff   <= wr_val;
               default: ;
            endcase
         end

         // result register, parted from the work by its own valid
         if (cmd.kind == egs_pkg::CMD_OUT) begin
            rsp_valid_ff <= 1'b1;
            case (cmd.outk)
               egs_pkg::OUT_BAD: begin
                  out_pub_ff    <= '0;
                  out_s1_ff     <= '0;
                  out_s2_ff     <= '0;
                  out_ok_ff     <= 1'b0;
                  out_status_ff <= 1'b1;
               end
               egs_pkg::OUT_NOINV: begin
                  out_pub_ff    <= pub_ff;
                  out_s1_ff     <= s1_ff;
                  out_s2_ff     <= '0;
                  out_ok_ff     <= 1'b0;
                  out_status_ff <= 1'b1;
               end
               egs_pkg::OUT_SIGN: begin
                  out_pub_ff    <= pub_ff;
                  out_s1_ff     <= s1_ff;
                  out_s2_ff     <= s2_ff;
                  out_ok_ff     <= 1'b0;
                  out_status_ff <= 1'b0;
               end
               default: begin
                  out_pub_ff    <= pub_ff;
                  out_s1_ff     <= '0;
                  out_s2_ff     <= '0;
                  out_ok_ff     <= (v1_ff == v2_ff);
                  out_status_ff <= 1'b0;
               end
            endcase
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.done      = done_ff;
   assign sts.ex_msb    = ex_ff[W-1];
   assign sts.r1_zero   = (r1_ff == '0);
   assign sts.r0_one    = (r0_ff == W'(1));
   assign sts.p_small   = (cfg_prime < W'(3));
   assign sts.op_verify = op_ff;
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_public_key = out_pub_ff;
   assign rsp_sig_first  = out_s1_ff;
   assign rsp_sig_second = out_s2_ff;
   assign rsp_sig_ok     = out_ok_ff;
   assign rsp_status     = out_status_ff;

endmodule

FILE: hw/rtl/egs_ctrl.sv
module egs_ctrl #(
   parameter int WORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  egs_pkg::sts_type sts,
   output egs_pkg::cmd_type cmd
);

   localparam int CNT_W = $clog2(WORD_BITS + 1);

   typedef enum logic [5:0] {
      ST_IDLE, ST_CHECK, ST_WAIT,
      ST_PW_RED, ST_PW_INIT, ST_PW_EX, ST_PW_SQ, ST_PW_BIT, ST_PW_SHIFT,
      ST_PUB_SAVE, ST_SG_S1,
      ST_IV_R0, ST_IV_R1, ST_IV_T0, ST_IV_T1, ST_IV_LOOP,
      ST_IV_MV0, ST_IV_MV1, ST_IV_QT, ST_IV_SUB, ST_IV_MT0, ST_IV_MT1, ST_IV_END,
      ST_SG_RS1, ST_SG_DS, ST_SG_M, ST_SG_DIF, ST_SG_S2,
      ST_VF_V1, ST_VF_V2, ST_VF_V3,
      ST_OUT
   } state_type;

   state_type             state_ff, state_in, ret_ff, ret_in, pw_ret_ff, pw_ret_in;
   egs_pkg::opd_type      pw_base_ff, pw_base_in, pw_ex_ff, pw_ex_in;
   egs_pkg::out_kind_type outk_ff, outk_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      pw_ret_in  = pw_ret_ff;
      pw_base_in = pw_base_ff;
      pw_ex_in   = pw_ex_ff;
      outk_in    = outk_ff;
      cnt_in     = cnt_ff;
      cmd        = '{kind: egs_pkg::CMD_NOP, a: egs_pkg::OPD_ZERO, b: egs_pkg::OPD_ZERO,
                     dst: egs_pkg::OPD_ZERO, mod_pm1: 1'b0, outk: outk_ff};
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.kind = egs_pkg::CMD_TAKE;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.p_small) begin
               outk_in  = egs_pkg::OUT_BAD;
               state_in = ST_OUT;
            end else begin
               pw_base_in = egs_pkg::OPD_G;
               pw_ex_in   = egs_pkg::OPD_D;
               pw_ret_in  = ST_PUB_SAVE;
               state_in   = ST_PW_RED;
            end
         end
         ST_WAIT: if (sts.done) state_in = ret_ff;
         // modular power: base reduced, exponent scanned MSB first
         ST_PW_RED: begin
            cmd = '{egs_pkg::CMD_MUL, pw_base_ff, egs_pkg::OPD_ONE, egs_pkg::OPD_BASE,
                    1'b0, outk_ff};
            state_in = ST_WAIT;
            ret_in   = ST_PW_INIT;
         end
         ST_PW_INIT: begin
            cmd = '{egs_pkg::CMD_LOAD, egs_pkg::OPD_ONE, egs_pkg::OPD_ZERO, egs_pkg::OPD_ACC,
                    1'b0, outk_ff};
            state_in = ST_PW_EX;
         end
         ST_PW_EX: begin
            cmd = '{egs_pkg::CMD_LOAD, pw_ex_ff, egs_pkg::OPD_ZERO, egs_pkg::OPD_EX,
                    1'b0, outk_ff};
            cnt_in   = CNT_W'(WORD_BITS);
            state_in = ST_PW_SQ;
         end
         ST_PW_SQ: begin
            if (cnt_ff == '0) begin
               state_in = pw_ret_ff;
            end else begin
               cmd = '{egs_pkg::CMD_MUL, egs_pkg::OPD_ACC, egs_pkg::OPD_ACC,
                       egs_pkg::OPD_ACC, 1'b0, outk_ff};
               state_in = ST_WAIT;
               ret_in   = ST_PW_BIT;
            end
         end
         ST_PW_BIT: begin
            if (sts.ex_msb) begin
               cmd = '{egs_pkg::CMD_MUL, egs_pkg::OPD_ACC, egs_pkg::OPD_BASE,
                       egs_pkg::OPD_ACC, 1'b0, outk_ff};
               state_in = ST_WAIT;
               ret_in   = ST_PW_SHIFT;
            end else begin
               state_in = ST_PW_SHIFT;
            end
         end
         ST_PW_SHIFT: begin
            cmd.kind = egs_pkg::CMD_SHL;
            cnt_in   = cnt_ff - CNT_W'(1);
            state_in = ST_PW_SQ;
         end
         ST_PUB_SAVE: begin
            cmd = '{egs_pkg::CMD_LOAD, egs_pkg::OPD_ACC, egs_pkg::OPD_ZERO, egs_pkg::OPD_PUB,
                    1'b0, outk_ff};
            pw_base_in = egs_pkg::OPD_G;
            pw_ex_in   = sts.op_verify ? egs_pkg::OPD_MSG : egs_pkg::OPD_NONCE;
            pw_ret_in  = sts.op_verify ? ST_VF_V1 : ST_SG_S1;
            state_in   = ST_PW_RED;
         end
         ST_SG_S1: begin
            cmd = '{egs_pkg::CMD_LOAD, egs_pkg::OPD_ACC, egs_pkg::OPD_ZERO, egs_pkg::OPD_S1,
                    1'b0, outk_ff};
            state_in = ST_IV_R0;
         end
         // extended Euclid, coefficients kept as residues mod p-1
         ST_IV_R0: begin
            cmd = '{egs_pkg::CMD_LOAD, egs_pkg::OPD_PM1, egs_pkg::OPD_ZERO, egs_pkg::OPD_R0,
                    1'b1, outk_ff};
            state_in = ST_IV_R1;
         end
         ST_IV_R1: begin
            cmd = '{egs_pkg::CMD_MUL, egs_pkg::OPD_NONCE, egs_pkg::OPD_ONE, egs_pkg::OPD_R1,
                    1'b1, outk_ff};
            state_in = ST_WAIT;
            ret_in   = ST_IV_T0;
         end
         ST_IV_T0: begin
            cmd = '{egs_pkg::CMD_LOAD, egs_pkg::OPD_ZERO, egs_pkg::OPD_ZERO, egs_pkg::OPD_T0,
                    1'b1, outk_ff};
            state_in = ST_IV_T1;
         end
         ST_IV_T1: begin
            cmd = '{egs_pkg::CMD_LOAD, egs_pkg::OPD_ONE, egs_pkg::OPD_ZERO, egs_pkg::OPD_T1,
                    1'b1, outk_ff};
            state_in = ST_IV_LOOP;
         end
         ST_IV_LOOP: begin
            if (sts.r1_zero) begin
               state_in = ST_IV_END;
            end else begin
               cmd = '{egs_pkg::CMD_DIV, egs_pkg::OPD_R0, egs_pkg::OPD_R1, egs_pkg::OPD_TMP,
                       1'b1, outk_ff};
               state_in = ST_WAIT;
               ret_in   = ST_IV_MV0;
            end
         end
         ST_IV_MV0: begin
            cmd = '{egs_pkg::CMD_LOAD, egs_pkg::OPD_R1, egs_pkg::OPD_ZERO, egs_pkg::OPD_R0,
                    1'b1, outk_ff};
            state_in = ST_IV_MV1;
         end
         ST_IV_MV1: begin
            cmd = '{egs_pkg::CMD_LOAD, egs_pkg::OPD_TMP, egs_pkg::OPD_ZERO, egs_pkg::OPD_R1,
                    1'b1, outk_ff};
            state_in = ST_IV_QT;
         end
         ST_IV_QT: begin
            cmd = '{egs_pkg::CMD_MUL, egs_pkg::OPD_Q, egs_pkg::OPD_T1, egs_pkg::OPD_TMP,
                    1'b1, outk_ff};
            state_in = ST_WAIT;
            ret_in   = ST_IV_SUB;
         end
         ST_IV_SUB: begin
            cmd = '{egs_pkg::CMD_SUBM, egs_pkg::OPD_T0, egs_pkg::OPD_TMP, egs_pkg::OPD_TMP,
                    1'b1, outk_ff};
            state_in = ST_IV_MT0;
         end
         ST_IV_MT0: begin
            cmd = '{egs_pkg::CMD_LOAD, egs_pkg::OPD_T1, egs_pkg::OPD_ZERO, egs_pkg::OPD_T0,
                    1'b1, outk_ff};
            state_in = ST_IV_MT1;
         end
         ST_IV_MT1: begin
            cmd = '{egs_pkg::CMD_LOAD, egs_pkg::OPD_TMP, egs_pkg::OPD_ZERO, egs_pkg::OPD_T1,
                    1'b1, outk_ff};
            state_in = ST_IV_LOOP;
         end
         ST_IV_END: begin
            if (sts.r0_one) begin
               state_in = ST_SG_RS1;
            end else begin
               outk_in  = egs_pkg::OUT_NOINV;
               state_in = ST_OUT;
            end
         end
         // S2 = (M - d*S1) * r^-1 mod p-1
         ST_SG_RS1: begin
            cmd = '{egs_pkg::CMD_MUL, egs_pkg::OPD_S1, egs_pkg::OPD_ONE, egs_pkg::OPD_TMP,
                    1'b1, outk_ff};
            state_in = ST_WAIT;
            ret_in   = ST_SG_DS;
         end
         ST_SG_DS: begin
            cmd = '{egs_pkg::CMD_MUL, egs_pkg::OPD_D, egs_pkg::OPD_TMP, egs_pkg::OPD_TMP,
                    1'b1, outk_ff};
            state_in = ST_WAIT;
            ret_in   = ST_SG_M;
         end
         ST_SG_M: begin
            cmd = '{egs_pkg::CMD_MUL, egs_pkg::OPD_MSG, egs_pkg::OPD_ONE, egs_pkg::OPD_V1,
                    1'b1, outk_ff};
            state_in = ST_WAIT;
            ret_in   = ST_SG_DIF;
         end
         ST_SG_DIF: begin
            cmd = '{egs_pkg::CMD_SUBM, egs_pkg::OPD_V1, egs_pkg::OPD_TMP, egs_pkg::OPD_TMP,
                    1'b1, outk_ff};
            state_in = ST_SG_S2;
         end
         ST_SG_S2: begin
            cmd = '{egs_pkg::CMD_MUL, egs_pkg::OPD_TMP, egs_pkg::OPD_T0, egs_pkg::OPD_S2,
                    1'b1, outk_ff};
            outk_in  = egs_pkg::OUT_SIGN;
            state_in = ST_WAIT;
            ret_in   = ST_OUT;
         end
         // g^M against y^S1 * S1^S2
         ST_VF_V1: begin
            cmd = '{egs_pkg::CMD_LOAD, egs_pkg::OPD_ACC, egs_pkg::OPD_ZERO, egs_pkg::OPD_V1,
                    1'b0, outk_ff};
            pw_base_in = egs_pkg::OPD_PUB;
            pw_ex_in   = egs_pkg::OPD_SIN1;
            pw_ret_in  = ST_VF_V2;
            state_in   = ST_PW_RED;
         end
         ST_VF_V2: begin
            cmd = '{egs_pkg::CMD_LOAD, egs_pkg::OPD_ACC, egs_pkg::OPD_ZERO, egs_pkg::OPD_V2,
                    1'b0, outk_ff};
            pw_base_in = egs_pkg::OPD_SIN1;
            pw_ex_in   = egs_pkg::OPD_SIN2;
            pw_ret_in  = ST_VF_V3;
            state_in   = ST_PW_RED;
         end
         ST_VF_V3: begin
            cmd = '{egs_pkg::CMD_MUL, egs_pkg::OPD_V2, egs_pkg::OPD_ACC, egs_pkg::OPD_V2,
                    1'b0, outk_ff};
            outk_in  = egs_pkg::OUT_VERIFY;
            state_in = ST_WAIT;
            ret_in   = ST_OUT;
         end
         ST_OUT: if (sts.rsp_free) begin
            cmd.kind = egs_pkg::CMD_OUT;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ret_ff     <= ret_in;
      pw_ret_ff  <= pw_ret_in;
      pw_base_ff <= pw_base_in;
      pw_ex_ff   <= pw_ex_in;
      outk_ff    <= outk_in;
      cnt_ff     <= cnt_in;
   end

endmodule

FILE: hw/rtl/elgamal_signature_engine.sv
// Channel | Direction | tdata (low bit up)                      | tuser
// req_    | in        | message, nonce, sig_first, sig_second   | op (0 sign, 1 verify)
// rsp_    | out       | public_key, sig_first_out, sig_second_out | signature_valid, status
// csr_    | in        | write enable, index (0 p, 1 g, 2 d), data | -
//
// One request at a time. Products and Euclid divides share one bit-serial unit.
// A power is a base reduction plus a square and at most one multiply per exponent bit.
// Sign: two powers, up to about 45 Euclid steps and five products. Verify: four powers and
// a product. Reset is synchronous and loads p=3119, g=2, d=127. A result held on a stalled
// rsp_ beat does not stop the next request from being taken; that one waits at its end.
module elgamal_signature_engine #(
   parameter int WORD_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // message, nonce, sig_first, sig_second
   input  logic [((4*WORD_BITS+7)/8)*8-1:0]      req_tdata,
   // op
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // public_key, sig_first_out, sig_second_out
   output logic [((3*WORD_BITS+7)/8)*8-1:0]      rsp_tdata,
   // signature_valid, status
   output logic [1:0]                            rsp_tuser,
   input  logic                                  csr_wr_en,
   input  logic [1:0]                            csr_index,
   input  logic [WORD_BITS-1:0]                  csr_wr_data
);

   localparam int W          = WORD_BITS;
   localparam int RSP_DATA_W = ((3*W+7)/8)*8;

   logic [W-1:0] prime_ff, gen_ff, key_ff;
   egs_pkg::cmd_type cmd;
   egs_pkg::sts_type sts;
   logic [W-1:0] out_pub, out_s1, out_s2;
   logic         out_ok, out_status;

   // configuration registers; the user must write them only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff <= egs_pkg::PRIME_RESET[W-1:0];
         gen_ff   <= egs_pkg::GEN_RESET[W-1:0];
         key_ff   <= egs_pkg::KEY_RESET[W-1:0];
      end else if (csr_wr_en) begin
         case (csr_index)
            egs_pkg::CSR_PRIME: prime_ff <= csr_wr_data;
            egs_pkg::CSR_GEN:   gen_ff   <= csr_wr_data;
            egs_pkg::CSR_KEY:   key_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   egs_ctrl #(.WORD_BITS(W)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   egs_datapath #(.WORD_BITS(W)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_op         (req_tuser),
      .req_message    (req_tdata[W-1:0]),
      .req_nonce      (req_tdata[2*W-1:W]),
      .req_sig_first  (req_tdata[3*W-1:2*W]),
      .req_sig_second (req_tdata[4*W-1:3*W]),
      .cfg_prime      (prime_ff),
      .cfg_gen        (gen_ff),
      .cfg_key        (key_ff),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_public_key (out_pub),
      .rsp_sig_first  (out_s1),
      .rsp_sig_second (out_s2),
      .rsp_sig_ok     (out_ok),
      .rsp_status     (out_status)
   );

   assign rsp_tdata = RSP_DATA_W'({out_s2, out_s1, out_pub});
   assign rsp_tuser = {out_status, out_ok};

endmodule

FILE: hw/rtl/egs_checker.sv
module egs_checker #(
   parameter int WORD_BITS = 32
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [((3*WORD_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic [1:0]                       rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in work");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared without any work");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("valid signature flagged together with error status");

endmodule

bind elgamal_signature_engine egs_checker #(.WORD_BITS(WORD_BITS)) u_egs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
